### rtl/pbfp_pkg.sv
package pbfp_pkg;

   localparam int unsigned MSG_LEN_W   = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_FIELD = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam logic [3:0] VARINT_LAST_CNT = 4'd9;
   localparam logic [7:0] CONT_BIT_MASK   = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       msg_start;
   } pbfp_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [28:0] field_number;
      logic [2:0]  wire_type;
      logic [63:0] field_value;
      logic [31:0] payload_offset;
      logic [31:0] payload_length;
      logic        last_result;
   } pbfp_rsp_type;

   // one queue entry: results caused by one byte
   typedef struct packed {
      logic        field_valid;
      logic [28:0] field_number;
      logic [2:0]  wire_type;
      logic [63:0] field_value;
      logic [31:0] payload_offset;
      logic [31:0] payload_length;
      logic        tail_valid;
      logic [1:0]  tail_kind;
   } pbfp_entry_type;

endpackage

### rtl/pbfp_front.sv
module pbfp_front
   import pbfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  pbfp_req_type         req_data,
   input  logic [MSG_LEN_W-1:0] msg_len,
   output logic                 push,
   output pbfp_entry_type       push_entry
);

   typedef enum logic [5:0] {
      PH_TAG    = 6'b000001,
      PH_VARINT = 6'b000010,
      PH_FIXED  = 6'b000100,
      PH_LENVAR = 6'b001000,
      PH_SKIP   = 6'b010000,
      PH_HALT   = 6'b100000
   } phase_type;

   logic [31:0] pos_ff, pos_in, pos_e;
   phase_type   phase_ff, phase_in, phase_e;
   logic [63:0] acc_ff, acc_in, acc_e;
   logic [3:0]  cnt_ff, cnt_in, cnt_e;
   logic [28:0] fnum_ff, fnum_in, fnum_e;
   logic [2:0]  wt_ff, wt_in, wt_e;
   logic [31:0] togo_ff, togo_in, togo_e;

   logic        active;
   logic        last;
   logic        bad;
   logic [31:0] pos_inc;
   logic [31:0] remaining;
   logic [6:0]  vshamt;
   logic [63:0] vacc;
   logic        vdone;
   logic        vlong;
   logic [7:0]  b;
   logic [31:0] need;
   logic [31:0] togo_dec;

   always_comb begin
      b        = req_data.data_byte;
      pos_e    = req_data.msg_start ? '0 : pos_ff;
      phase_e  = req_data.msg_start ? PH_TAG : phase_ff;
      acc_e    = req_data.msg_start ? '0 : acc_ff;
      cnt_e    = req_data.msg_start ? '0 : cnt_ff;
      fnum_e   = req_data.msg_start ? '0 : fnum_ff;
      wt_e     = req_data.msg_start ? '0 : wt_ff;
      togo_e   = req_data.msg_start ? '0 : togo_ff;

      active    = accept && (phase_e != PH_HALT) && (pos_e < msg_len);
      pos_inc   = pos_e + 32'd1;
      last      = (pos_inc == msg_len);
      remaining = msg_len - pos_inc;
      togo_dec  = togo_e - 32'd1;

      // varint step
      vshamt = 7'(cnt_e) * 7'd7;
      vacc   = acc_e;
      if (vshamt < 7'd64) begin
         vacc = acc_e | ({57'd0, b[6:0]} << vshamt[5:0]);
      end
      vdone = ((b & CONT_BIT_MASK) == 8'd0);
      vlong = !vdone && (cnt_e >= VARINT_LAST_CNT);
      need  = (vacc[2:0] == WT_FIXED64) ? 32'd8 : 32'd4;

      pos_in   = pos_ff;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      fnum_in  = fnum_ff;
      wt_in    = wt_ff;
      togo_in  = togo_ff;
      bad      = 1'b0;
      push_entry = '0;

      if (accept) begin
         pos_in   = pos_e;
         phase_in = phase_e;
         acc_in   = acc_e;
         cnt_in   = cnt_e;
         fnum_in  = fnum_e;
         wt_in    = wt_e;
         togo_in  = togo_e;
      end

      if (active) begin
         pos_in = pos_inc;
         case (phase_e)
            PH_TAG: begin
               acc_in = vacc;
               cnt_in = cnt_e + 4'd1;
               if (vlong) begin
                  bad = 1'b1;
               end else if (vdone) begin
                  acc_in = '0;
                  cnt_in = '0;
                  if ((vacc[63:32] != 32'd0) || (vacc[31:3] == 29'd0)) begin
                     bad = 1'b1;
                  end else begin
                     fnum_in = vacc[31:3];
                     wt_in   = vacc[2:0];
                     if (vacc[2:0] == WT_VARINT) begin
                        phase_in = PH_VARINT;
                     end else if ((vacc[2:0] == WT_FIXED64) ||
                                  (vacc[2:0] == WT_FIXED32)) begin
                        if (remaining < need) begin
                           bad = 1'b1;
                        end else begin
                           togo_in  = need;
                           phase_in = PH_FIXED;
                        end
                     end else if (vacc[2:0] == WT_LEN) begin
                        phase_in = PH_LENVAR;
                     end else begin
                        bad = 1'b1;
                     end
                  end
               end
            end
            PH_VARINT: begin
               acc_in = vacc;
               cnt_in = cnt_e + 4'd1;
               if (vlong) begin
                  bad = 1'b1;
               end else if (vdone) begin
                  push_entry.field_valid  = 1'b1;
                  push_entry.field_number = fnum_e;
                  push_entry.wire_type    = WT_VARINT;
                  push_entry.field_value  = vacc;
                  phase_in = PH_TAG;
                  acc_in   = '0;
                  cnt_in   = '0;
                  fnum_in  = '0;
                  wt_in    = '0;
                  togo_in  = '0;
               end
            end
            PH_FIXED: begin
               acc_in  = acc_e | ({56'd0, b} << {cnt_e[2:0], 3'b000});
               cnt_in  = cnt_e + 4'd1;
               togo_in = togo_dec;
               if (togo_dec == 32'd0) begin
                  push_entry.field_valid  = 1'b1;
                  push_entry.field_number = fnum_e;
                  push_entry.wire_type    = wt_e;
                  push_entry.field_value  = acc_in;
                  phase_in = PH_TAG;
                  acc_in   = '0;
                  cnt_in   = '0;
                  fnum_in  = '0;
                  wt_in    = '0;
               end
            end
            PH_LENVAR: begin
               acc_in = vacc;
               cnt_in = cnt_e + 4'd1;
               if (vlong) begin
                  bad = 1'b1;
               end else if (vdone) begin
                  if (vacc > {32'd0, remaining}) begin
                     bad = 1'b1;
                  end else begin
                     push_entry.field_valid    = 1'b1;
                     push_entry.field_number   = fnum_e;
                     push_entry.wire_type      = WT_LEN;
                     push_entry.payload_offset = pos_inc;
                     push_entry.payload_length = vacc[31:0];
                     phase_in = (vacc[31:0] != 32'd0) ? PH_SKIP : PH_TAG;
                     togo_in  = vacc[31:0];
                     acc_in   = '0;
                     cnt_in   = '0;
                     fnum_in  = '0;
                     wt_in    = '0;
                  end
               end
            end
            PH_SKIP: begin
               if (togo_e != 32'd0) begin
                  togo_in = togo_dec;
               end
               if ((togo_e == 32'd0) || (togo_dec == 32'd0)) begin
                  togo_in  = '0;
                  phase_in = PH_TAG;
               end
            end
            default: begin
               phase_in = phase_e;
            end
         endcase

         if (bad || last) begin
            push_entry.tail_valid = 1'b1;
            if (!bad && (phase_in == PH_TAG) && (cnt_in == 4'd0)) begin
               push_entry.tail_kind = KIND_END;
            end else begin
               push_entry.tail_kind = KIND_ERROR;
            end
            phase_in = PH_HALT;
            acc_in   = '0;
            cnt_in   = '0;
            fnum_in  = '0;
            wt_in    = '0;
            togo_in  = '0;
         end
      end

      push = active && (push_entry.field_valid || push_entry.tail_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_TAG;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         fnum_ff  <= '0;
         wt_ff    <= '0;
         togo_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         fnum_ff  <= fnum_in;
         wt_ff    <= wt_in;
         togo_ff  <= togo_in;
      end
   end

endmodule

### rtl/pbfp_queue.sv
module pbfp_queue
   import pbfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pbfp_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output pbfp_entry_type head
);

   pbfp_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue overflow");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty)) else $error("queue underflow");

   a_count_drops_on_pop: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - QUEUE_CNT_W'(1)))
      else $error("queue count did not drop on pop");

   a_empty_ptrs_equal: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

### rtl/pbfp_back.sv
module pbfp_back
   import pbfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           not_empty,
   input  pbfp_entry_type head,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output pbfp_rsp_type   rsp_data,
   output logic           pop
);

   logic tail_stage_ff, tail_stage_in;
   logic show_tail;
   logic transfer;

   always_comb begin
      show_tail = tail_stage_ff || !head.field_valid;
      rsp_valid = not_empty;
      transfer  = rsp_valid && rsp_ready;
      pop       = transfer && (show_tail || !head.tail_valid);

      tail_stage_in = tail_stage_ff;
      if (pop) begin
         tail_stage_in = 1'b0;
      end else if (transfer) begin
         tail_stage_in = 1'b1;
      end

      rsp_data = '0;
      if (show_tail) begin
         rsp_data.result_kind = head.tail_kind;
         rsp_data.last_result = 1'b1;
      end else begin
         rsp_data.result_kind    = KIND_FIELD;
         rsp_data.field_number   = head.field_number;
         rsp_data.wire_type      = head.wire_type;
         rsp_data.field_value    = head.field_value;
         rsp_data.payload_offset = head.payload_offset;
         rsp_data.payload_length = head.payload_length;
         rsp_data.last_result    = !head.tail_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_stage_ff <= 1'b0;
      end else begin
         tail_stage_ff <= tail_stage_in;
      end
   end

   a_tail_stage_has_pair: assert property (@(posedge clock) disable iff (reset)
      tail_stage_ff |-> (not_empty && head.field_valid && head.tail_valid))
      else $error("tail stage without a field and tail pair");

endmodule

### rtl/protobuf_field_parser.sv
// results: each result is registered in the result queue and offered from its head
// throughput: one byte per cycle while the result queue is not full; a byte causing a field and an
// end or error yields two results from a single entry, absorbed by a four-entry result queue
// reset: synchronous, clears parse state and queue, message length returns to 1
module protobuf_field_parser
   import pbfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pbfp_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pbfp_rsp_type         rsp_data,
   input  logic                 csr_write_enable,
   input  logic [MSG_LEN_W-1:0] csr_write_data
);

   logic [MSG_LEN_W-1:0] msg_len_ff, msg_len_in;
   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 full;
   logic                 not_empty;
   pbfp_entry_type       push_entry;
   pbfp_entry_type       head;

   assign req_ready  = !full;
   assign accept     = req_valid && req_ready;
   assign msg_len_in = csr_write_enable ? csr_write_data : msg_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_len_ff <= MSG_LEN_W'(1);
      end else begin
         msg_len_ff <= msg_len_in;
      end
   end

   pbfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .msg_len    (msg_len_ff),
      .push       (push),
      .push_entry (push_entry)
   );

   pbfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   pbfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .pop       (pop)
   );

endmodule

### bench/protobuf_field_parser_checker.sv
module protobuf_field_parser_checker
   import pbfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  pbfp_req_type         req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pbfp_rsp_type         rsp_data,
   input  logic                 csr_write_enable,
   input  logic [MSG_LEN_W-1:0] csr_write_data,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      ST_TAG,
      ST_VALUE,
      ST_FIXED,
      ST_LENGTH,
      ST_SKIP,
      ST_HALT
   } parse_step_type;

   logic [31:0]    msg_len;
   logic [31:0]    byte_pos;
   logic [31:0]    skip_left;
   parse_step_type phase;
   logic [63:0]    accum;
   logic [3:0]     group_cnt;
   logic [28:0]    cur_field;
   logic [2:0]     cur_type;
   pbfp_rsp_type   field_results_q[$];

   function automatic void clear_field();
      phase     = ST_TAG;
      accum     = '0;
      group_cnt = '0;
      cur_field = '0;
      cur_type  = '0;
      skip_left = '0;
   endfunction

   // 1 when the varint ends, 0 when more follows, -1 when it runs too long
   function automatic int take_group(logic [7:0] b);
      int shift;
      shift = 7 * group_cnt;
      if (shift < 64) accum |= {57'd0, b[6:0]} << shift;
      group_cnt++;
      if (!b[7]) return 1;
      if (group_cnt >= 4'd10) return -1;
      return 0;
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [28:0] num, logic [2:0] wt,
                                       logic [63:0] val, logic [31:0] off, logic [31:0] len);
      pbfp_rsp_type r;
      r = '{result_kind: kind, field_number: num, wire_type: wt, field_value: val,
            payload_offset: off, payload_length: len, last_result: 1'b0};
      field_results_q.push_back(r);
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic start);
      logic [31:0]  at;
      logic [31:0]  room;
      logic [31:0]  need;
      logic [63:0]  tag;
      logic         is_last;
      logic         bad;
      int           st;
      int           first;
      pbfp_rsp_type r;
      bad   = 1'b0;
      first = field_results_q.size();
      if (start) begin
         byte_pos = '0;
         clear_field();
      end
      if (phase == ST_HALT || byte_pos >= msg_len) return;
      at       = byte_pos;
      byte_pos = at + 1;
      is_last  = (at + 1 == msg_len);
      room     = msg_len - (at + 1);
      case (phase)
         ST_TAG: begin
            st = take_group(b);
            if (st < 0) begin
               bad = 1'b1;
            end else if (st > 0) begin
               tag       = accum;
               accum     = '0;
               group_cnt = '0;
               if (tag[63:32] != 0 || tag[31:3] == 0) begin
                  bad = 1'b1;
               end else begin
                  cur_field = tag[31:3];
                  cur_type  = tag[2:0];
                  case (tag[2:0])
                     WT_VARINT: phase = ST_VALUE;
                     WT_FIXED64, WT_FIXED32: begin
                        need = (tag[2:0] == WT_FIXED64) ? 32'd8 : 32'd4;
                        if (room < need) begin
                           bad = 1'b1;
                        end else begin
                           skip_left = need;
                           phase     = ST_FIXED;
                        end
                     end
                     WT_LEN: phase = ST_LENGTH;
                     default: bad = 1'b1;
                  endcase
               end
            end
         end
         ST_VALUE: begin
            st = take_group(b);
            if (st < 0) begin
               bad = 1'b1;
            end else if (st > 0) begin
               push_result(KIND_FIELD, cur_field, WT_VARINT, accum, '0, '0);
               clear_field();
            end
         end
         ST_FIXED: begin
            accum |= {56'd0, b} << ((8 * group_cnt) & 63);
            group_cnt++;
            skip_left--;
            if (skip_left == 0) begin
               push_result(KIND_FIELD, cur_field, cur_type, accum, '0, '0);
               clear_field();
            end
         end
         ST_LENGTH: begin
            st = take_group(b);
            if (st < 0) begin
               bad = 1'b1;
            end else if (st > 0) begin
               if (accum > {32'd0, room}) begin
                  bad = 1'b1;
               end else begin
                  need = accum[31:0];
                  push_result(KIND_FIELD, cur_field, WT_LEN, '0, at + 1, need);
                  clear_field();
                  if (need != 0) begin
                     skip_left = need;
                     phase     = ST_SKIP;
                  end
               end
            end
         end
         ST_SKIP: begin
            if (skip_left != 0) skip_left--;
            if (skip_left == 0) phase = ST_TAG;
         end
         default: ;
      endcase
      if (bad) begin
         push_result(KIND_ERROR, '0, '0, '0, '0, '0);
         clear_field();
         phase = ST_HALT;
      end else if (is_last) begin
         if (phase == ST_TAG && group_cnt == 0) push_result(KIND_END, '0, '0, '0, '0, '0);
         else push_result(KIND_ERROR, '0, '0, '0, '0, '0);
         clear_field();
         phase = ST_HALT;
      end
      if (field_results_q.size() > first) begin
         r = field_results_q.pop_back();
         r.last_result = 1'b1;
         field_results_q.push_back(r);
      end
   endfunction

   function automatic void log_mismatch(string what, pbfp_rsp_type want, pbfp_rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: result %s", $time, what);
         $display("  expected kind %0d field %0d type %0d value %h off %0d len %0d last %0b",
                  want.result_kind, want.field_number, want.wire_type, want.field_value,
                  want.payload_offset, want.payload_length, want.last_result);
         $display("  actual   kind %0d field %0d type %0d value %h off %0d len %0d last %0b",
                  got.result_kind, got.field_number, got.wire_type, got.field_value,
                  got.payload_offset, got.payload_length, got.last_result);
      end
   endfunction

   function automatic void check_result(pbfp_rsp_type got);
      pbfp_rsp_type want;
      string        diffs;
      if (field_results_q.size() == 0) begin
         log_mismatch("with nothing expected", '0, got);
         return;
      end
      want  = field_results_q.pop_front();
      diffs = "";
      if (got.result_kind !== want.result_kind) diffs = {diffs, " kind"};
      if (got.field_number !== want.field_number) diffs = {diffs, " field_number"};
      if (got.wire_type !== want.wire_type) diffs = {diffs, " wire_type"};
      if (got.field_value !== want.field_value) diffs = {diffs, " field_value"};
      if (got.payload_offset !== want.payload_offset) diffs = {diffs, " payload_offset"};
      if (got.payload_length !== want.payload_length) diffs = {diffs, " payload_length"};
      if (got.last_result !== want.last_result) diffs = {diffs, " last_result"};
      if (diffs != "") log_mismatch({"wrong in", diffs}, want, got);
   endfunction

   // results are registered in the queue, never offered with their own byte, so check before predicting
   always @(posedge clock) begin
      if (reset) begin
         msg_len  = 32'd1;
         byte_pos = '0;
         clear_field();
         field_results_q.delete();
      end else begin
         if (csr_write_enable) msg_len = csr_write_data;
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) decode_byte(req_data.data_byte, req_data.msg_start);
      end
      pending = field_results_q.size();
   end

endmodule

### bench/protobuf_field_parser_tb.sv
module protobuf_field_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbfp_pkg::*;

   localparam int RANDOM_ITEMS = 1050;
   localparam int CALM_AFTER   = 900;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 2000;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   pbfp_req_type         req_data         = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   pbfp_rsp_type         rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [MSG_LEN_W-1:0] csr_write_data   = '0;

   int         fail_count;
   int         pending;
   int         hold_asks = 0;
   bit         calm      = 1'b0;
   int         quiet     = 0;
   logic [7:0] msg[$];

   protobuf_field_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   protobuf_field_parser_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : receiver
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != served) begin
            served = hold_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, msg_start: start};
      do @(posedge clock); while (!req_ready);
   endtask

   // register writes only once every result is out and the block has settled
   task automatic set_length(input logic [31:0] len);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_message(input logic [31:0] len, input bit noisy);
      int   i;
      logic start;
      set_length(len);
      for (i = 0; i < msg.size(); i++) begin
         start = (i == 0);
         if (noisy && $urandom_range(0, 39) == 0) start = ~start;
         send_byte(msg[i], start);
      end
   endtask

   function automatic void put_varint(logic [63:0] v, int pad);
      int          n;
      int          i;
      logic [63:0] t;
      n = 1;
      t = v >> 7;
      while (t != 0) begin
         n++;
         t = t >> 7;
      end
      n = n + pad;
      if (n > 10) n = 10;
      for (i = 0; i < n; i++) begin
         t = v >> (7 * i);
         msg.push_back({i != n - 1, t[6:0]});
      end
   endfunction

   function automatic int pad_count();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic void put_tag(logic [28:0] num, logic [2:0] wt);
      put_varint({32'd0, num, wt}, pad_count());
   endfunction

   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 4))
         0: return 64'($urandom_range(0, 127));
         1: return 64'($urandom);
         2: return {$urandom, $urandom};
         3: return '1;
         default: return 64'($urandom_range(0, 20000));
      endcase
   endfunction

   function automatic logic [28:0] rand_field_number();
      logic [28:0] num;
      case ($urandom_range(0, 3))
         0: num = 29'($urandom_range(1, 15));
         1: num = 29'($urandom_range(16, 2047));
         2: num = '1;
         default: num = 29'($urandom);
      endcase
      return (num == 0) ? 29'd1 : num;
   endfunction

   function automatic void put_good_field();
      logic [28:0] num;
      logic [63:0] v;
      int          n;
      int          i;
      num = rand_field_number();
      v   = rand_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            put_tag(num, WT_VARINT);
            put_varint(v, pad_count());
         end
         4, 5: begin
            put_tag(num, WT_FIXED64);
            for (i = 0; i < 8; i++) msg.push_back(v[8*i +: 8]);
         end
         6, 7: begin
            put_tag(num, WT_FIXED32);
            for (i = 0; i < 4; i++) msg.push_back(v[8*i +: 8]);
         end
         default: begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            put_tag(num, WT_LEN);
            put_varint(64'(n), pad_count());
            for (i = 0; i < n; i++) msg.push_back(8'($urandom));
         end
      endcase
   endfunction

   function automatic void put_bad_field();
      logic [28:0] num;
      logic [2:0]  wt;
      int          i;
      num = rand_field_number();
      case ($urandom_range(0, 4))
         0: begin
            wt = $urandom_range(0, 1) ? 3'($urandom_range(3, 4)) : 3'($urandom_range(6, 7));
            put_tag(num, wt);
            repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
         end
         1: put_tag('0, $urandom_range(0, 1) ? WT_VARINT : WT_LEN);
         2: put_varint({32'($urandom_range(1, 32'hffff_ffff)), 32'($urandom)}, 0);
         3: begin
            case ($urandom_range(0, 2))
               0: put_tag(num, WT_VARINT);
               1: put_tag(num, WT_LEN);
               default: ;
            endcase
            for (i = 0; i < 10; i++) msg.push_back(8'h80 | 8'($urandom_range(0, 127)));
         end
         default: begin
            put_tag(num, WT_LEN);
            put_varint(rand_value() | 64'h100, 0);
         end
      endcase
   endfunction

   function automatic void build_message();
      int nf;
      int bad_at;
      int i;
      msg.delete();
      nf     = $urandom_range(1, 6);
      bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nf - 1) : -1;
      for (i = 0; i < nf; i++) begin
         if (i == bad_at) put_bad_field();
         else put_good_field();
      end
   endfunction

   initial begin : stimulus
      int          useful;
      int          i;
      bit          pressed;
      logic [31:0] len;
      useful  = 0;
      pressed = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero length register: the byte is dropped
      msg = '{8'hff};
      send_message(32'd0, 1'b0);
      // field number zero
      msg = '{8'h00};
      send_message(32'd1, 1'b0);
      // cut off right after a tag
      msg = '{8'h08};
      send_message(32'd1, 1'b0);
      // wire type 3, then a byte after the halt
      msg = '{8'h0b, 8'h55};
      send_message(32'd2, 1'b0);
      // fixed32 with too few bytes left
      msg = '{8'h0d, 8'h01};
      send_message(32'd2, 1'b0);
      // empty payload, then a length past the end
      msg = '{8'h12, 8'h00, 8'h12, 8'h05};
      send_message(32'd4, 1'b0);
      // fixed32 and varint ending cleanly
      msg = '{8'h0d, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h10, 8'h01};
      send_message(32'd7, 1'b0);
      // tag varint that never stops
      msg.delete();
      repeat (10) msg.push_back(8'hff);
      send_message(32'd12, 1'b0);

      while (useful < RANDOM_ITEMS) begin
         if (!pressed && useful >= RANDOM_ITEMS / 3) begin
            pressed = 1'b1;
            msg.delete();
            for (i = 0; i < 50; i++) begin
               msg.push_back(8'($urandom_range(1, 15) << 3));
               msg.push_back(8'($urandom_range(0, 127)));
            end
            set_length(msg.size());
            hold_asks++;
            for (i = 0; i < msg.size(); i++) send_byte(msg[i], i == 0);
            useful += msg.size();
         end
         build_message();
         case ($urandom_range(0, 29))
            0, 1: len = $urandom_range(1, msg.size());
            2, 3: len = msg.size() + $urandom_range(1, 5);
            4: len = '1;
            5: len = '0;
            default: len = msg.size();
         endcase
         if (len != 0) useful += (len < msg.size()) ? len : msg.size();
         // stray bytes past the end
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
         send_message(len, 1'b1);
         if (useful >= CALM_AFTER) calm = 1'b1;
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/pbfp_pkg.sv
rtl/pbfp_front.sv
rtl/pbfp_queue.sv
rtl/pbfp_back.sv
rtl/protobuf_field_parser.sv
bench/protobuf_field_parser_checker.sv
bench/protobuf_field_parser_tb.sv
